/* rtl/assert_macros.svh */
// Assertion macros shared by the tokenizer RTL.
// Expect i_clk and i_rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, held off during reset.
`define SQLTOK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sqltok check failed");

// Same-cycle implication.
`define SQLTOK_ASSERT_IMPL(lbl, ante, cons) \
    `SQLTOK_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication.
`define SQLTOK_ASSERT_NEXT(lbl, ante, cons) \
    `SQLTOK_ASSERT(lbl, (ante) |=> (cons))

`endif

/* rtl/sqltok_pkg.sv */
// Package for the SQL keyword tokenizer: widths, codes, token structs,
// keyword tables and character-class helpers. No dependencies.
`default_nettype none

package sqltok_pkg;

    localparam int MAX_TOKEN_LEN = 256;
    localparam int TLEN_W        = $clog2(MAX_TOKEN_LEN + 2);
    localparam int KIND_W        = 5;
    localparam int OLEN_W        = 9;
    localparam int LINE_W        = 24;
    localparam int COL_W         = 16;
    localparam int NUM_KW        = 8;
    localparam int NUM_OP        = 5;
    localparam int FIFO_DEPTH    = 4;
    localparam int PTR_W         = $clog2(FIFO_DEPTH);
    localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_ESCAPE
    } t_mode;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_END     = 5'd0;
    localparam t_kind KIND_ILLEGAL = 5'd1;
    localparam t_kind KIND_IDENT   = 5'd2;
    localparam t_kind KIND_INT     = 5'd3;
    localparam t_kind KIND_FLOAT   = 5'd4;
    localparam t_kind KIND_STR_DQ  = 5'd5;
    localparam t_kind KIND_OP_BASE = 5'd8;
    localparam t_kind KIND_KW_BASE = 5'd13;

    localparam logic [1:0] QUOTE_DQ = 2'd0;
    localparam logic [1:0] QUOTE_SQ = 2'd1;
    localparam logic [1:0] QUOTE_BQ = 2'd2;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BQ    = 8'h60;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_US    = 8'h5F;

    localparam logic [7:0] OP_CHARS [NUM_OP] = '{8'h28, 8'h29, 8'h3B, 8'h2C, 8'h3D};

    // Keyword text, right-aligned and zero-padded on the left.
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        "create", "drop", "use", "database", "table", "int", "float", "varchar"
    };
    localparam int KW_LEN [NUM_KW] = '{6, 4, 3, 8, 5, 3, 5, 7};

    typedef struct packed {
        t_kind              kind;
        logic [OLEN_W-1:0]  length;
        logic               too_long;
        logic [LINE_W-1:0]  line;
        logic [COL_W-1:0]   col;
        logic               last;
    } t_token;

    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token t0;
        t_token t1;
    } t_result_pair;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
    endfunction

    // Character p of keyword k; zero past its end.
    function automatic logic [7:0] kw_char(input int k, input int p);
        logic [63:0] w;
        w = KW_TEXT[k];
        if (p >= KW_LEN[k]) begin
            return 8'h00;
        end
        return w[8*(KW_LEN[k]-1-p) +: 8];
    endfunction

    // Drop keywords whose character at position p differs from lc.
    function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] cands,
                                                    input logic [TLEN_W-1:0] p,
                                                    input logic [7:0] lc);
        logic [NUM_KW-1:0] keep;
        for (int k = 0; k < NUM_KW; k++) begin
            keep[k] = cands[k] && (int'(p) < KW_LEN[k]) && (kw_char(k, int'(p)) == lc);
        end
        return keep;
    endfunction

    function automatic t_kind ident_kind(input logic [NUM_KW-1:0] cands,
                                         input logic [TLEN_W-1:0] len);
        t_kind kind;
        kind = KIND_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (cands[k] && int'(len) == KW_LEN[k]) begin
                kind = KIND_KW_BASE + KIND_W'(k);
            end
        end
        return kind;
    endfunction

    function automatic logic [TLEN_W-1:0] grow(input logic [TLEN_W-1:0] len);
        return (int'(len) <= MAX_TOKEN_LEN) ? len + 1'b1 : len;
    endfunction

    function automatic t_token make_token(input t_kind kind,
                                          input logic [TLEN_W-1:0] len,
                                          input logic [LINE_W-1:0] line,
                                          input logic [COL_W-1:0] col);
        t_token t;
        t.kind     = kind;
        t.too_long = int'(len) > MAX_TOKEN_LEN;
        t.length   = t.too_long ? OLEN_W'(MAX_TOKEN_LEN) : OLEN_W'(len);
        t.line     = line;
        t.col      = col;
        t.last     = 1'b0;
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/sqltok_ifs.sv */
// Valid/ready channel interfaces for the tokenizer: text input and token output.
// Depends on sqltok_pkg.
`default_nettype none

interface sqltok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_end;

    modport source (output valid, output text_byte, output is_end, input ready);
    modport sink   (input valid, input text_byte, input is_end, output ready);
endinterface

interface sqltok_out_if;
    import sqltok_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;
    logic [OLEN_W-1:0] token_length;
    logic              too_long;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column_number;
    logic              last_of_run;

    modport source (output valid, output token_kind, output token_length, output too_long,
                    output line_number, output column_number, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_length, input too_long,
                    input line_number, input column_number, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

/* rtl/sqltok_scan.sv */
// Scanner state and per-byte decision logic; emits up to two tokens per byte.
// Depends on sqltok_pkg.
`default_nettype none

module sqltok_scan (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_fire,
    input  wire logic [7:0]             i_text_byte,
    input  wire logic                   i_is_end,
    output sqltok_pkg::t_result_pair    o_pair
);
    import sqltok_pkg::*;

    t_mode              r_mode,  n_mode;
    logic [TLEN_W-1:0]  r_len,   n_len;
    logic               r_dot,   n_dot;
    logic [1:0]         r_quote, n_quote;
    logic [NUM_KW-1:0]  r_cands, n_cands;
    logic [LINE_W-1:0]  r_line,  n_line;
    logic [COL_W-1:0]   r_col,   n_col;

    logic [7:0]         c;
    logic [7:0]         lc;
    logic [7:0]         quote_ch;
    logic [LINE_W-1:0]  post_line;
    logic [COL_W-1:0]   post_col;

    // start-of-token decode
    t_mode              s_mode;
    logic [TLEN_W-1:0]  s_len;
    logic               s_dot;
    logic [1:0]         s_quote;
    logic [NUM_KW-1:0]  s_cands;
    logic               s_emit;
    t_token             s_tok;

    logic               pre_v, post_v;
    t_token             pre_tok, post_tok;

    assign c  = i_text_byte;
    assign lc = to_lower(c);

    always_comb begin
        case (r_quote)
            QUOTE_DQ: quote_ch = CH_DQ;
            QUOTE_SQ: quote_ch = CH_SQ;
            QUOTE_BQ: quote_ch = CH_BQ;
            default:  quote_ch = 8'h00;
        endcase
    end

    // Counters after this byte.
    always_comb begin
        post_line = r_line;
        post_col  = r_col;
        if (c == CH_NL) begin
            if (r_line != '1) begin
                post_line = r_line + 1'b1;
            end
            post_col = COL_W'(1);
        end else if (r_col != '1) begin
            post_col = r_col + 1'b1;
        end
    end

    always_comb begin
        s_mode  = MODE_IDLE;
        s_len   = '0;
        s_dot   = 1'b0;
        s_quote = r_quote;
        s_cands = r_cands;
        s_emit  = 1'b0;
        s_tok   = make_token(KIND_ILLEGAL, TLEN_W'(1), post_line, post_col);
        if (c == CH_DQ) begin
            s_mode  = MODE_STRING;
            s_quote = QUOTE_DQ;
        end else if (c == CH_SQ) begin
            s_mode  = MODE_STRING;
            s_quote = QUOTE_SQ;
        end else if (c == CH_BQ) begin
            s_mode  = MODE_STRING;
            s_quote = QUOTE_BQ;
        end else if (is_alpha(c) || c == CH_US) begin
            s_mode  = MODE_IDENT;
            s_cands = kw_filter('1, '0, lc);
            s_len   = TLEN_W'(1);
        end else if (is_digit(c) || c == CH_DOT) begin
            s_mode = MODE_NUMBER;
            s_dot  = (c == CH_DOT);
            s_len  = TLEN_W'(1);
        end else begin
            for (int o = 0; o < NUM_OP; o++) begin
                if (c == OP_CHARS[o]) begin
                    s_emit     = 1'b1;
                    s_tok.kind = KIND_OP_BASE + KIND_W'(o);
                end
            end
            if (!is_space(c)) begin
                s_emit = 1'b1;
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_len    = r_len;
        n_dot    = r_dot;
        n_quote  = r_quote;
        n_cands  = r_cands;
        n_line   = r_line;
        n_col    = r_col;
        pre_v    = 1'b0;
        post_v   = 1'b0;
        pre_tok  = make_token(KIND_ILLEGAL, r_len, r_line, r_col);
        post_tok = s_tok;

        if (i_fire && i_is_end) begin
            case (r_mode)
                MODE_IDENT: begin
                    pre_v        = 1'b1;
                    pre_tok.kind = ident_kind(r_cands, r_len);
                end
                MODE_NUMBER: begin
                    pre_v        = 1'b1;
                    pre_tok.kind = r_dot ? KIND_FLOAT : KIND_INT;
                end
                MODE_STRING, MODE_ESCAPE: begin
                    pre_v = 1'b1;
                end
                default: begin
                    pre_v = 1'b0;
                end
            endcase
            post_v   = 1'b1;
            post_tok = make_token(KIND_END, '0, r_line, r_col);
            // back to the reset state for the next text
            n_mode  = MODE_IDLE;
            n_len   = '0;
            n_dot   = 1'b0;
            n_quote = QUOTE_DQ;
            n_cands = '1;
            n_line  = LINE_W'(1);
            n_col   = COL_W'(1);
        end else if (i_fire) begin
            n_line = post_line;
            n_col  = post_col;
            case (r_mode)
                MODE_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == CH_US) begin
                        n_cands = kw_filter(r_cands, r_len, lc);
                        n_len   = grow(r_len);
                    end else begin
                        pre_v        = 1'b1;
                        pre_tok.kind = ident_kind(r_cands, r_len);
                        n_mode  = s_mode;
                        n_len   = s_len;
                        n_dot   = s_dot;
                        n_quote = s_quote;
                        n_cands = s_cands;
                        post_v  = s_emit;
                    end
                end
                MODE_NUMBER: begin
                    if (is_digit(c)) begin
                        n_len = grow(r_len);
                    end else if (c == CH_DOT && !r_dot) begin
                        n_dot = 1'b1;
                        n_len = grow(r_len);
                    end else if (c == CH_DOT) begin
                        // second dot: flush digits as an ILLEGAL token, restart number at the dot
                        pre_v = 1'b1;
                        n_len = TLEN_W'(1);
                    end else begin
                        pre_v        = 1'b1;
                        pre_tok.kind = r_dot ? KIND_FLOAT : KIND_INT;
                        n_mode  = s_mode;
                        n_len   = s_len;
                        n_dot   = s_dot;
                        n_quote = s_quote;
                        n_cands = s_cands;
                        post_v  = s_emit;
                    end
                end
                MODE_STRING: begin
                    if (c == quote_ch) begin
                        post_v   = 1'b1;
                        post_tok = make_token(KIND_STR_DQ + KIND_W'(r_quote), r_len,
                                              post_line, post_col);
                        n_mode   = MODE_IDLE;
                        n_len    = '0;
                    end else if (c == CH_BSL) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        n_len = grow(r_len);
                    end
                end
                MODE_ESCAPE: begin
                    n_len  = grow(r_len);
                    n_mode = MODE_STRING;
                    if (c == CH_LOW_N) begin
                        if (post_line != '1) begin
                            n_line = post_line + 1'b1;
                        end
                        n_col = COL_W'(1);
                    end
                end
                default: begin
                    n_mode  = s_mode;
                    n_len   = s_len;
                    n_dot   = s_dot;
                    n_quote = s_quote;
                    n_cands = s_cands;
                    post_v  = s_emit;
                end
            endcase
        end
    end

    // Pack into slots in emission order, mark the final one.
    always_comb begin
        if (pre_v) begin
            o_pair.v0 = 1'b1;
            o_pair.t0 = pre_tok;
            o_pair.v1 = post_v;
            o_pair.t1 = post_tok;
        end else begin
            o_pair.v0 = post_v;
            o_pair.t0 = post_tok;
            o_pair.v1 = 1'b0;
            o_pair.t1 = post_tok;
        end
        o_pair.t0.last = !o_pair.v1;
        o_pair.t1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_len   <= '0;
            r_dot   <= 1'b0;
            r_quote <= QUOTE_DQ;
            r_cands <= '1;
            r_line  <= LINE_W'(1);
            r_col   <= COL_W'(1);
        end else begin
            r_mode  <= n_mode;
            r_len   <= n_len;
            r_dot   <= n_dot;
            r_quote <= n_quote;
            r_cands <= n_cands;
            r_line  <= n_line;
            r_col   <= n_col;
        end
    end

endmodule

`default_nettype wire

/* rtl/sqltok_fifo.sv */
// Small token queue between the scanner and the output channel.
// Takes up to two tokens per cycle, delivers one. Depends on sqltok_pkg.
`default_nettype none

module sqltok_fifo (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire sqltok_pkg::t_result_pair i_pair,
    output logic                        o_space,
    output logic                        o_valid,
    input  wire logic                   i_pop,
    output sqltok_pkg::t_token          o_head
);
    import sqltok_pkg::*;

    t_token             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wr_next;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    // room for the worst case of two tokens from one byte
    assign o_space = (int'(r_count) <= FIFO_DEPTH - 2);
    assign pop     = i_pop && o_valid;
    assign wr_next = r_wr + 1'b1;

    always_comb begin
        n_wr    = r_wr + PTR_W'(i_pair.v0) + PTR_W'(i_pair.v1);
        n_rd    = pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count + CNT_W'(i_pair.v0) + CNT_W'(i_pair.v1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_pair.v0) begin
            r_mem[r_wr] <= i_pair.t0;
        end
        if (i_pair.v1) begin
            r_mem[wr_next] <= i_pair.t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

/* rtl/sql_keyword_tokenizer.sv */
// Top level of the SQL keyword tokenizer: scanner plus output token queue.
// Depends on sqltok_pkg, sqltok_ifs, sqltok_scan, sqltok_fifo, assert_macros.svh.
//
//  Port    Dir  Carries                          Per transfer
//  i_in    in   text_byte, is_end                one text byte or end mark
//  o_out   out  token_kind .. last_of_run        one token
//
// One byte is taken per cycle while i_in.ready is high; the scanner decides it
// in the same cycle and the resulting zero, one or two tokens land in a
// four-entry queue, visible the next cycle. i_in.ready is high while the queue
// has room for two tokens. Reset is synchronous and active low and returns
// line and column to 1; no warm-up sweep is needed.
`default_nettype none

`include "assert_macros.svh"

module sql_keyword_tokenizer (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sqltok_in_if.sink    i_in,
    sqltok_out_if.source o_out
);
    import sqltok_pkg::*;

    logic           w_fire;
    logic           w_space;
    t_result_pair   w_pair;
    t_token         w_head;

    assign i_in.ready = w_space;
    assign w_fire     = i_in.valid && w_space;

    sqltok_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_text_byte (i_in.text_byte),
        .i_is_end    (i_in.is_end),
        .o_pair      (w_pair)
    );

    sqltok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (w_pair),
        .o_space (w_space),
        .o_valid (o_out.valid),
        .i_pop   (o_out.ready),
        .o_head  (w_head)
    );

    assign o_out.token_kind    = w_head.kind;
    assign o_out.token_length  = w_head.length;
    assign o_out.too_long      = w_head.too_long;
    assign o_out.line_number   = w_head.line;
    assign o_out.column_number = w_head.col;
    assign o_out.last_of_run   = w_head.last;

    `SQLTOK_ASSERT_NEXT(a_end_gives_token, w_fire && i_in.is_end, o_out.valid)
    `SQLTOK_ASSERT_IMPL(a_second_needs_first, w_pair.v1, w_pair.v0 && !w_pair.t0.last)
    `SQLTOK_ASSERT_IMPL(a_line_nonzero, o_out.valid, o_out.line_number != '0)

endmodule

`default_nettype wire
